// File: design/plc_pkg.sv
// Package for the positional list engine: transaction types, codes and cell control.
package plc_pkg;

	// Default sizes handed to the top level parameters.
	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;

	// Command kind codes carried in the three-bit kind field.
	localparam logic [2:0] KIND_INSERT  = 3'd0;
	localparam logic [2:0] KIND_REMOVE  = 3'd1;
	localparam logic [2:0] KIND_READ    = 3'd2;
	localparam logic [2:0] KIND_REPLACE = 3'd3;
	localparam logic [2:0] KIND_CLEAR   = 3'd4;

	// Result status codes.
	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_BADPOS = 2'd1;
	localparam logic [1:0] STATUS_FULL   = 2'd2;

	// One command transaction.
	typedef struct packed {
		logic [2:0]  kind;
		logic [4:0]  position;
		logic [31:0] value;
	} cmd_t;

	// One result transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [4:0]  length;
		logic        empty_res;
	} res_t;

	// Operation broadcast along the row of cells.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE,
		CELL_WRITE
	} cell_op_t;

	// Control seen by one cell: the operation and where the cell lies against the position.
	typedef struct packed {
		cell_op_t op;
		logic     sel_at;
		logic     sel_above;
	} cell_ctrl_t;

endpackage

// File: design/plc_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbours.
module plc_cell #(
	parameter int VALUE_BITS = plc_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  plc_pkg::cell_ctrl_t    ctrl,
	input  logic [VALUE_BITS-1:0]  left_val,
	input  logic [VALUE_BITS-1:0]  right_val,
	input  logic [VALUE_BITS-1:0]  new_val,
	output logic [VALUE_BITS-1:0]  val
);

	logic [VALUE_BITS-1:0] val_q;
	logic [VALUE_BITS-1:0] val_d;

	// Choose the next entry: shift from a neighbour, take the new value, or hold.
	always_comb begin
		val_d = val_q;
		case (ctrl.op)
			plc_pkg::CELL_INSERT: begin
				if (ctrl.sel_at) begin
					val_d = new_val;
				end else if (ctrl.sel_above) begin
					val_d = left_val;
				end
			end
			plc_pkg::CELL_REMOVE: begin
				if (ctrl.sel_at || ctrl.sel_above) begin
					val_d = right_val;
				end
			end
			plc_pkg::CELL_WRITE: begin
				if (ctrl.sel_at) begin
					val_d = new_val;
				end
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	// The entry itself carries no reset; it is undefined until written.
	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

	assign val = val_q;

endmodule

// File: design/positional_list_engine.sv
// Top level of the positional list engine: command decode, length counter and cell row.
//
// A bounded ordered list of up to CAPACITY entries addressed by one-based
// position. A command transaction (insert, remove, read, replace or clear) is
// accepted at a rising edge where start is high and busy is low; busy is
// never raised, so a command may be issued in every cycle.
//
// Each command gives exactly one result transaction: done is high for one
// cycle, the cycle after the command is accepted, with status, read value,
// length and empty flag on res. The receiver cannot stall, so res must be
// taken in that cycle. Throughput is one command per clock cycle.
//
// Every entry lives in a cell of its own. An insert or remove shifts all
// cells at or past the position by one place in the same cycle, so the cost
// does not depend on the position or the length.
//
// Reset empties the list (length zero) and clears done. The entries are not
// cleared; only entries written since reset can ever be read back.
module positional_list_engine #(
	parameter int CAPACITY   = plc_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = plc_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  plc_pkg::cmd_t cmd,
	output logic          done,
	output plc_pkg::res_t res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	logic                  accept;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic [PW-1:0]         pos_w;
	logic [PW-1:0]         count_w;
	logic                  pos_ok;
	logic                  pos_ok_ins;
	logic                  full;
	logic [IW-1:0]         rd_idx;
	logic [63:0]           new_wide;
	logic [VALUE_BITS-1:0] new_val;
	logic [63:0]           rd_wide;
	logic [1:0]            status_d;
	logic [31:0]           rd_d;
	plc_pkg::cell_op_t     op_d;
	plc_pkg::cell_ctrl_t   ctrl [CAPACITY];
	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic                  done_q;
	plc_pkg::res_t         res_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Position checks against the current length.
	assign pos_w      = PW'(cmd.position);
	assign count_w    = PW'(count_q);
	assign pos_ok     = (cmd.position != 5'd0) && (pos_w <= count_w);
	assign pos_ok_ins = (cmd.position != 5'd0) && (pos_w <= count_w + PW'(1));
	assign full       = (count_w == PW'(CAPACITY));
	assign rd_idx     = IW'(pos_w - PW'(1));

	// Fit the incoming value to the stored entry width.
	assign new_wide = 64'(cmd.value);
	assign new_val  = new_wide[VALUE_BITS-1:0];
	assign rd_wide  = 64'(cell_val[rd_idx]);

	// Decode the command into status, read data, new length and cell operation.
	always_comb begin
		status_d = plc_pkg::STATUS_OK;
		rd_d     = 32'd0;
		count_d  = count_q;
		op_d     = plc_pkg::CELL_HOLD;
		case (cmd.kind)
			plc_pkg::KIND_INSERT: begin
				if (!pos_ok_ins) begin
					status_d = plc_pkg::STATUS_BADPOS;
				end else if (full) begin
					status_d = plc_pkg::STATUS_FULL;
				end else begin
					op_d    = plc_pkg::CELL_INSERT;
					count_d = count_q + CW'(1);
				end
			end
			plc_pkg::KIND_REMOVE: begin
				if (!pos_ok) begin
					status_d = plc_pkg::STATUS_BADPOS;
				end else begin
					op_d    = plc_pkg::CELL_REMOVE;
					count_d = count_q - CW'(1);
				end
			end
			plc_pkg::KIND_READ: begin
				if (!pos_ok) begin
					status_d = plc_pkg::STATUS_BADPOS;
				end else begin
					rd_d = rd_wide[31:0];
				end
			end
			plc_pkg::KIND_REPLACE: begin
				if (!pos_ok) begin
					status_d = plc_pkg::STATUS_BADPOS;
				end else begin
					op_d = plc_pkg::CELL_WRITE;
				end
			end
			plc_pkg::KIND_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = plc_pkg::STATUS_OK;
			end
		endcase
		if (!accept) begin
			op_d    = plc_pkg::CELL_HOLD;
			count_d = count_q;
		end
	end

	// Tell each cell whether it sits at the position or beyond it.
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ctrl[i].op        = op_d;
			ctrl[i].sel_at    = (pos_w == PW'(i + 1));
			ctrl[i].sel_above = (pos_w <= PW'(i));
		end
	end

	// The row of cells; the ends take the new value or their own entry.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VALUE_BITS-1:0] left_v;
		logic [VALUE_BITS-1:0] right_v;
		if (g == 0) begin : g_first
			assign left_v = new_val;
		end else begin : g_inner_l
			assign left_v = cell_val[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[g];
		end else begin : g_inner_r
			assign right_v = cell_val[g+1];
		end
		plc_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl[g]),
			.left_val  (left_v),
			.right_val (right_v),
			.new_val   (new_val),
			.val       (cell_val[g])
		);
	end

	// Length counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// Result register, loaded with every accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.status     <= status_d;
			res_q.read_value <= rd_d;
			res_q.length     <= 5'(count_d);
			res_q.empty_res  <= (count_d == '0);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// File: tb/sv/positional_list_engine_test.sv
// Self-checking testbench for the positional list engine: random and directed commands.
module positional_list_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_DEPTH = plc_pkg::CAPACITY_DEF;
	localparam int RANDOM_CMDS = 1500;

	// Kind codes that the block treats as no operation.
	localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;

	// Contents of the list as the block should hold them.
	typedef struct packed {
		logic [LIST_DEPTH-1:0][31:0] entries;
		logic [4:0]                  count;
	} list_state_t;

	logic           clk;
	logic           arst_n;
	logic           start = 1'b0;
	logic           busy;
	plc_pkg::cmd_t  cmd = '0;
	logic           done;
	plc_pkg::res_t  res;

	plc_pkg::cmd_t pending_cmds[$];
	plc_pkg::res_t expected_results[$];
	list_state_t   plan_state;
	list_state_t   model_state;
	int            gap_left = 0;
	bit            steady = 1'b0;
	int            errors = 0;
	int            kind_tally[8];
	int            results_seen = 0;
	int            badpos_seen = 0;
	int            full_seen = 0;
	int            longest_list = 0;

	positional_list_engine #(
		.CAPACITY  (LIST_DEPTH),
		.VALUE_BITS(plc_pkg::VALUE_BITS_DEF)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.done  (done),
		.res   (res)
	);

	// Applies one command to a copy of the list and returns the result it gives.
	function automatic plc_pkg::res_t apply_command(inout list_state_t st,
			input plc_pkg::cmd_t c);
		plc_pkg::res_t r;
		int unsigned   pos;
		int unsigned   n;
		int unsigned   i;
		r = '0;
		pos = c.position;
		n = st.count;
		case (c.kind)
			plc_pkg::KIND_INSERT: begin
				if (pos < 1 || pos > n + 1) begin
					r.status = plc_pkg::STATUS_BADPOS;
				end else if (n >= LIST_DEPTH) begin
					r.status = plc_pkg::STATUS_FULL;
				end else begin
					// Entries at or past the position move up by one place.
					for (i = n; i > pos - 1; i--)
						st.entries[i] = st.entries[i-1];
					st.entries[pos-1] = c.value;
					st.count = 5'(n + 1);
				end
			end
			plc_pkg::KIND_REMOVE: begin
				if (pos < 1 || pos > n) begin
					r.status = plc_pkg::STATUS_BADPOS;
				end else begin
					for (i = pos - 1; i + 1 < n; i++)
						st.entries[i] = st.entries[i+1];
					st.count = 5'(n - 1);
				end
			end
			plc_pkg::KIND_READ: begin
				if (pos < 1 || pos > n)
					r.status = plc_pkg::STATUS_BADPOS;
				else
					r.read_value = st.entries[pos-1];
			end
			plc_pkg::KIND_REPLACE: begin
				if (pos < 1 || pos > n)
					r.status = plc_pkg::STATUS_BADPOS;
				else
					st.entries[pos-1] = c.value;
			end
			plc_pkg::KIND_CLEAR: begin
				st.count = '0;
			end
			default: begin
			end
		endcase
		r.length = st.count;
		r.empty_res = (st.count == 5'd0);
		return r;
	endfunction

	// Queues a command and tracks the list length it leaves, for shaping later positions.
	task automatic queue_cmd(input logic [2:0] kind, input logic [4:0] pos,
			input logic [31:0] value);
		plc_pkg::cmd_t c;
		c.kind = kind;
		c.position = pos;
		c.value = value;
		void'(apply_command(plan_state, c));
		pending_cmds.push_back(c);
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$error("Mismatch on %s: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			errors++;
		end
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: issues queued commands, with random gaps and stretches without gaps.
	always @(posedge clk) begin
		int unsigned roll;
		int          next_gap;
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			// A command transaction completes at this edge.
			if (start && !busy) begin
				expected_results.push_back(apply_command(model_state, cmd));
				kind_tally[cmd.kind]++;
			end
			if (start && busy) begin
				// Hold the command until the block takes it.
			end else if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				if ($urandom_range(99, 0) == 0)
					steady = !steady;
				roll = $urandom_range(99, 0);
				if (steady || roll < 65)
					next_gap = 0;
				else if (roll < 93)
					next_gap = int'($urandom_range(3, 1));
				else
					next_gap = int'($urandom_range(40, 8));
				cmd <= pending_cmds.pop_front();
				start <= 1'b1;
				gap_left <= next_gap;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: checks every result transaction against the oldest expectation.
	always @(posedge clk) begin
		plc_pkg::res_t exp_res;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (expected_results.size() == 0) begin
					$error("Result transaction with no command outstanding");
					errors++;
				end else begin
					exp_res = expected_results.pop_front();
					check_field("status", 32'(exp_res.status), 32'(res.status));
					check_field("read_value", exp_res.read_value, res.read_value);
					check_field("length", 32'(exp_res.length), 32'(res.length));
					check_field("empty_res", 32'(exp_res.empty_res), 32'(res.empty_res));
					results_seen++;
					if (exp_res.status == plc_pkg::STATUS_BADPOS)
						badpos_seen++;
					if (exp_res.status == plc_pkg::STATUS_FULL)
						full_seen++;
					if (int'(exp_res.length) > longest_list)
						longest_list = int'(exp_res.length);
				end
			end else if (done !== 1'b0) begin
				$error("Strobe done is unknown");
				errors++;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int unsigned n;
		int unsigned roll;
		int unsigned limit;
		bit          grow;
		logic [2:0]  kind;
		logic [4:0]  pos;
		logic [31:0] value;

		arst_n = 1'b0;
		plan_state = '0;
		model_state = '0;
		grow = 1'b1;

		// Reads, removes, replaces and an insert past the end of an empty list are rejected.
		queue_cmd(plc_pkg::KIND_READ, 5'd1, 32'h0);
		queue_cmd(plc_pkg::KIND_REMOVE, 5'd0, 32'h0);
		queue_cmd(plc_pkg::KIND_REPLACE, 5'd1, 32'hFFFF_FFFF);
		queue_cmd(plc_pkg::KIND_INSERT, 5'd2, 32'h1234_5678);
		// Removing the only entry leaves the list empty.
		queue_cmd(plc_pkg::KIND_INSERT, 5'd1, 32'h0);
		queue_cmd(plc_pkg::KIND_REMOVE, 5'd1, 32'h0);
		// Fill the list, inserting at the head, the tail and the middle.
		for (n = 0; n < LIST_DEPTH; n++) begin
			if (n % 3 == 0)
				pos = 5'd1;
			else if (n % 3 == 1)
				pos = plan_state.count + 5'd1;
			else
				pos = 5'(plan_state.count / 2 + 1);
			queue_cmd(plc_pkg::KIND_INSERT, pos,
				(n % 2 == 0) ? 32'hFFFF_FFFF : $urandom());
		end
		// A full list refuses a valid insert; a bad position is reported first.
		queue_cmd(plc_pkg::KIND_INSERT, 5'(LIST_DEPTH + 1), 32'hA5A5_A5A5);
		queue_cmd(plc_pkg::KIND_INSERT, 5'(LIST_DEPTH + 2), 32'h5A5A_5A5A);
		queue_cmd(plc_pkg::KIND_REPLACE, 5'(LIST_DEPTH), 32'h0);
		queue_cmd(plc_pkg::KIND_READ, 5'(LIST_DEPTH), 32'h0);
		queue_cmd(plc_pkg::KIND_READ, 5'(LIST_DEPTH + 1), 32'h0);
		// An unused kind does nothing, then the list is cleared.
		queue_cmd(KIND_UNUSED_LAST, 5'd31, 32'hFFFF_FFFF);
		queue_cmd(plc_pkg::KIND_CLEAR, 5'd31, 32'h0);

		// Random part: phases that grow or shrink the list, mostly valid positions.
		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 80 == 0)
				grow = 1'($urandom_range(1, 0));
			roll = $urandom_range(99, 0);
			if (roll < 1)
				kind = plc_pkg::KIND_CLEAR;
			else if (roll < 4)
				kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
			else if (roll < 50)
				kind = grow ? plc_pkg::KIND_INSERT : plc_pkg::KIND_REMOVE;
			else if (roll < 60)
				kind = grow ? plc_pkg::KIND_REMOVE : plc_pkg::KIND_INSERT;
			else if (roll < 80)
				kind = plc_pkg::KIND_READ;
			else
				kind = plc_pkg::KIND_REPLACE;
			limit = 32'(plan_state.count);
			if (kind == plc_pkg::KIND_INSERT)
				limit++;
			roll = $urandom_range(99, 0);
			if (limit > 0 && roll < 85)
				pos = 5'($urandom_range(limit, 1));
			else if (roll < 92)
				pos = 5'(limit + 1);
			else if (roll < 95)
				pos = 5'd0;
			else
				pos = 5'($urandom_range(31, 0));
			roll = $urandom_range(99, 0);
			if (roll < 10)
				value = 32'h0;
			else if (roll < 20)
				value = 32'hFFFF_FFFF;
			else
				value = $urandom();
			queue_cmd(kind, pos, value);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for every command to be taken and every result to arrive.
		@(negedge clk);
		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);

		$display("Covered %0d commands: %0d insert, %0d remove, %0d read, %0d replace, %0d clear",
			results_seen, kind_tally[plc_pkg::KIND_INSERT], kind_tally[plc_pkg::KIND_REMOVE],
			kind_tally[plc_pkg::KIND_READ], kind_tally[plc_pkg::KIND_REPLACE],
			kind_tally[plc_pkg::KIND_CLEAR]);
		$display("Rejected positions %0d, inserts into a full list %0d, longest list %0d",
			badpos_seen, full_seen, longest_list);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Guard against a hung run.
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: filelist.f
design/plc_pkg.sv
design/plc_cell.sv
design/positional_list_engine.sv
tb/sv/positional_list_engine_test.sv
